[sv/odr_pkg.sv]
// Shared types, constants and helper functions for the ordered dither depth reducer.
// Used by odr_position and ordered_dither_depth_reducer; depends on nothing else.
package odr_pkg;

	localparam int DIM_BITS     = 12;
	localparam int MATRIX_ORDER = 4;
	localparam int MO_BITS      = $clog2(MATRIX_ORDER);
	localparam int CHAN_W       = 8;
	localparam int OFFSET_W     = 3;
	localparam int DEPTH_W      = 4;
	localparam int SIZE_W       = 13;
	localparam int CFG_W        = 13;
	localparam int CFG_IDX_W    = 2;

	localparam logic [SIZE_W-1:0]   SIZE_TOP  = SIZE_W'(1) << DIM_BITS;
	localparam logic [DEPTH_W-1:0]  DEPTH_MAX = DEPTH_W'(CHAN_W);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BITS_PER_CHANNEL = 2'd0,
		CFG_DITHER_ENABLE    = 2'd1,
		CFG_FRAME_WIDTH      = 2'd2,
		CFG_FRAME_HEIGHT     = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [OFFSET_W-1:0] offset;
		logic                eol;
		logic                eof;
	} pos_info_t;

	localparam logic [OFFSET_W-1:0] DITHER_TABLE [MATRIX_ORDER][MATRIX_ORDER] = '{
		'{3'd0, 3'd4, 3'd1, 3'd5},
		'{3'd6, 3'd2, 3'd7, 3'd3},
		'{3'd1, 3'd5, 3'd0, 3'd4},
		'{3'd7, 3'd3, 3'd6, 3'd2}
	};

	// Last counter position for a configured size, with zero and oversize clamped.
	function automatic logic [DIM_BITS-1:0] last_pos(input logic [SIZE_W-1:0] size);
		logic [SIZE_W-1:0] lim;
		lim = size;
		if (size == '0) begin
			lim = SIZE_W'(1);
		end else if (size > SIZE_TOP) begin
			lim = SIZE_TOP;
		end
		return DIM_BITS'(lim - SIZE_W'(1));
	endfunction

	// Keep mask for a configured depth, with out-of-range depths clamped.
	function automatic logic [CHAN_W-1:0] keep_mask(input logic [DEPTH_W-1:0] bits);
		logic [DEPTH_W-1:0] keep;
		logic [2:0]         drop;
		keep = bits;
		if (bits == '0) begin
			keep = DEPTH_W'(1);
		end else if (bits > DEPTH_MAX) begin
			keep = DEPTH_MAX;
		end
		drop = 3'(DEPTH_MAX - keep);
		return {CHAN_W{1'b1}} << drop;
	endfunction

	// Adds the offset, saturates at full scale and clears the dropped bits.
	function automatic logic [CHAN_W-1:0] reduce_chan(
		input logic [CHAN_W-1:0]   v,
		input logic [OFFSET_W-1:0] off,
		input logic [CHAN_W-1:0]   mask
	);
		logic [CHAN_W:0]   sum;
		logic [CHAN_W-1:0] sat;
		sum = {1'b0, v} + {{(CHAN_W + 1 - OFFSET_W){1'b0}}, off};
		sat = sum[CHAN_W] ? {CHAN_W{1'b1}} : sum[CHAN_W-1:0];
		return sat & mask;
	endfunction

endpackage

[sv/odr_position.sv]
// Column and row counters that track the raster position of each accepted item.
// Gives the dither offset and the line and frame end flags; uses odr_pkg.
module odr_position (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic                        dither_en,
	input  logic [odr_pkg::SIZE_W-1:0]  frame_width,
	input  logic [odr_pkg::SIZE_W-1:0]  frame_height,
	output odr_pkg::pos_info_t          pos
);
	import odr_pkg::*;

	logic [DIM_BITS-1:0] col_q;
	logic [DIM_BITS-1:0] row_q;
	logic [DIM_BITS-1:0] col_last;
	logic [DIM_BITS-1:0] row_last;

	always_comb begin
		col_last   = last_pos(frame_width);
		row_last   = last_pos(frame_height);
		pos.eol    = (col_q >= col_last);
		pos.eof    = pos.eol && (row_q >= row_last);
		pos.offset = dither_en ? DITHER_TABLE[row_q[MO_BITS-1:0]][col_q[MO_BITS-1:0]] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (pos.eol) begin
				col_q <= '0;
				row_q <= pos.eof ? '0 : row_q + DIM_BITS'(1);
			end else begin
				col_q <= col_q + DIM_BITS'(1);
			end
		end
	end

endmodule

[sv/ordered_dither_depth_reducer.sv]
// Ordered 4x4 dither and color depth reduction of an RGB888 pixel stream.
// An accepted item is held in the input register, and its result is loaded into the output
// register once that register is free. Throughput is one item per cycle while out_stall is low.
// One new item can still be taken while a result waits, if the input register is free.
// Reset clears the position counters and pipeline valids and loads the register defaults.
// Uses odr_pkg and odr_position.
module ordered_dither_depth_reducer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [odr_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [odr_pkg::CFG_W-1:0]     wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [odr_pkg::CHAN_W-1:0]    in_red,
	input  logic [odr_pkg::CHAN_W-1:0]    in_green,
	input  logic [odr_pkg::CHAN_W-1:0]    in_blue,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [odr_pkg::CHAN_W-1:0]    out_red,
	output logic [odr_pkg::CHAN_W-1:0]    out_green,
	output logic [odr_pkg::CHAN_W-1:0]    out_blue,
	output logic                          end_of_line,
	output logic                          end_of_frame
);
	import odr_pkg::*;

	logic [DEPTH_W-1:0] bits_q;
	logic               dith_en_q;
	logic [SIZE_W-1:0]  width_q;
	logic [SIZE_W-1:0]  height_q;

	logic               in_acc;
	logic               adv_s2;
	pos_info_t          pos;
	logic [CHAN_W-1:0]  mask;

	logic               valid_s1;
	logic [CHAN_W-1:0]  red_s1;
	logic [CHAN_W-1:0]  green_s1;
	logic [CHAN_W-1:0]  blue_s1;
	pos_info_t          pos_s1;

	logic               valid_s2;
	logic [CHAN_W-1:0]  red_s2;
	logic [CHAN_W-1:0]  green_s2;
	logic [CHAN_W-1:0]  blue_s2;
	logic               eol_s2;
	logic               eof_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q    <= DEPTH_W'(8);
			dith_en_q <= 1'b1;
			width_q   <= SIZE_W'(640);
			height_q  <= SIZE_W'(480);
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				CFG_BITS_PER_CHANNEL: bits_q    <= wr_data[DEPTH_W-1:0];
				CFG_DITHER_ENABLE:    dith_en_q <= wr_data[0];
				CFG_FRAME_WIDTH:      width_q   <= wr_data[SIZE_W-1:0];
				CFG_FRAME_HEIGHT:     height_q  <= wr_data[SIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign adv_s2   = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv_s2;
	assign in_acc   = in_valid && !in_stall;

	odr_position u_position (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (in_acc),
		.dither_en    (dith_en_q),
		.frame_width  (width_q),
		.frame_height (height_q),
		.pos          (pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			red_s1   <= in_red;
			green_s1 <= in_green;
			blue_s1  <= in_blue;
			pos_s1   <= pos;
		end
	end

	assign mask = keep_mask(bits_q);

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			red_s2   <= reduce_chan(red_s1, pos_s1.offset, mask);
			green_s2 <= reduce_chan(green_s1, pos_s1.offset, mask);
			blue_s2  <= reduce_chan(blue_s1, pos_s1.offset, mask);
			eol_s2   <= pos_s1.eol;
			eof_s2   <= pos_s1.eof;
		end
	end

	assign out_valid    = valid_s2;
	assign out_red      = red_s2;
	assign out_green    = green_s2;
	assign out_blue     = blue_s2;
	assign end_of_line  = eol_s2;
	assign end_of_frame = eof_s2;

	a_eof_has_eol: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!end_of_frame || end_of_line))
		else $error("frame end flagged without line end");

	a_low_bits_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (((out_red | out_green | out_blue) & ~mask) == '0))
		else $error("dropped bits not cleared");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && out_stall) |=> (valid_s1 && $stable(red_s1)))
		else $error("input register overwritten while pipeline stalled");

endmodule
